[rtl/core/mhnt_pkg.sv]
// Shared constants, codes and types of the MIDI hanging-note tracker.
// Depends on nothing; every module of the tracker imports it.
package mhnt_pkg;

   localparam int CHANNELS    = 16;
   localparam int PITCHES     = 128;
   localparam int COUNT_WIDTH = 8;

   localparam int SLOTS    = CHANNELS * PITCHES;
   localparam int ADDR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CURSOR_W = 11;
   localparam int CHAN_W   = 4;
   localparam int KEY_W    = 7;

   localparam logic [CURSOR_W:0]    SLOTS_C   = (CURSOR_W + 1)'(SLOTS);
   localparam logic [ADDR_W-1:0]    WIPE_LAST = ADDR_W'(SLOTS - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [7:0] KIND_MASK = 8'hf0;
   localparam logic [7:0] CHAN_MASK = 8'h0f;
   localparam logic [7:0] KIND_OFF  = 8'h80;
   localparam logic [7:0] KIND_ON   = 8'h90;

   // request commands
   localparam logic [1:0] CMD_TRACK = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_FETCH = 2'd2;

   // classified operations handed from front to back
   localparam logic [2:0] OP_NOP   = 3'd0;
   localparam logic [2:0] OP_INC   = 3'd1;
   localparam logic [2:0] OP_DEC   = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_FETCH = 3'd4;

   typedef struct packed {
      logic [2:0]        code;
      logic [ADDR_W-1:0] addr;
   } op_type;

   typedef struct packed {
      logic       note_off_valid;
      logic [7:0] note_off_status;
      logic [6:0] note_off_key;
      logic       scan_done;
      logic [7:0] note_count;
   } rsp_type;

   typedef struct packed {
      logic init_busy;
   } back_stat_type;

   function automatic logic [7:0] count_to_byte(input logic [COUNT_WIDTH-1:0] c);
      logic [15:0] wide;
      wide = 16'(c);
      return wide[7:0];
   endfunction

endpackage

[rtl/core/midi_hanging_note_tracker_core.sv]
// Top level of the MIDI hanging-note tracker.
// Depends on mhnt_pkg, mhnt_front and mhnt_back.
//
// Usage: requests enter through a queue-like port (req_push / req_full) and
// carry a command with a MIDI status byte, key and velocity. Each request gives
// exactly one result, read from a second queue-like port (rsp_empty / rsp_pop);
// the oldest result sits on the rsp_ ports while rsp_empty is low.
// Operations: a track request is a read-modify-write of one counter in the back
// end; clear and unused commands are answered without a store access, but clear
// then occupies the store while it zeroes all SLOTS (2048) counters. A fetch
// reads one counter a cycle through the single read port, scanning on from the
// cursor until it finds a nonzero counter or passes the last slot.
// Reset: the store is swept to zero; req_full stays high for that whole sweep
// and the scan cursor starts at slot zero.
// Stalls: a two-entry request queue parts the front from the back, and a
// two-entry result queue parts the back from the receiver; when the result
// queue fills, the back end holds and the request queue then fills in turn.
module midi_hanging_note_tracker_core import mhnt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_command,
   input  logic [7:0] req_status_byte,
   input  logic [6:0] req_key_number,
   input  logic [6:0] req_velocity,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_note_off_valid,
   output logic [7:0] rsp_note_off_status,
   output logic [6:0] rsp_note_off_key,
   output logic       rsp_scan_done,
   output logic [7:0] rsp_note_count
);

   logic          op_valid;
   op_type        op;
   logic          op_take;
   rsp_type       rsp_item;
   back_stat_type back_stat;

   // classify and queue requests; hold off new requests during the reset sweep
   mhnt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .hold            (back_stat.init_busy),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_status_byte (req_status_byte),
      .req_key_number  (req_key_number),
      .req_velocity    (req_velocity),
      .op_valid        (op_valid),
      .op              (op),
      .op_take         (op_take)
   );

   // carry out the operations on the counter store and queue the results
   mhnt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .op_take   (op_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .stat      (back_stat)
   );

   assign rsp_note_off_valid  = rsp_item.note_off_valid;
   assign rsp_note_off_status = rsp_item.note_off_status;
   assign rsp_note_off_key    = rsp_item.note_off_key;
   assign rsp_scan_done       = rsp_item.scan_done;
   assign rsp_note_count      = rsp_item.note_count;

   // no result can appear before the reset sweep has finished
   assert property (@(posedge clock) disable iff (reset)
      back_stat.init_busy |-> rsp_empty)
      else $error("result queued during reset sweep");

   // a fetch either finds a note or reports the end of the store, never both
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_note_off_valid && rsp_scan_done))
      else $error("found note and end of scan flagged together");

   // a found note is always reported as a note-off
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_note_off_valid) |-> (rsp_note_off_status[7:4] == 4'h8))
      else $error("released note without note-off status");

   // the back end takes no operation while the store is being swept at reset
   assert property (@(posedge clock) disable iff (reset)
      back_stat.init_busy |-> !op_take)
      else $error("operation taken during reset sweep");

endmodule

[rtl/core/mhnt_front.sv]
// Front part of the hanging-note tracker: classifies requests and queues them.
// Depends on mhnt_pkg.
module mhnt_front import mhnt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             hold,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_command,
   input  logic [7:0]       req_status_byte,
   input  logic [6:0]       req_key_number,
   input  logic [6:0]       req_velocity,
   output logic             op_valid,
   output op_type           op,
   input  logic             op_take
);

   op_type              q_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                push, pop;
   op_type              cls;
   logic [7:0]          kind;
   logic [CHAN_W-1:0]   chan;
   logic                in_range;
   logic [CURSOR_W:0]   lin;

   always_comb begin
      kind     = req_status_byte & KIND_MASK;
      chan     = CHAN_W'(req_status_byte & CHAN_MASK);
      in_range = ({1'b0, chan} < (CHAN_W + 1)'(CHANNELS)) &&
                 ({1'b0, req_key_number} < (KEY_W + 1)'(PITCHES));
      lin      = (CURSOR_W + 1)'(chan) * (CURSOR_W + 1)'(PITCHES)
                 + (CURSOR_W + 1)'(req_key_number);
      cls.addr = lin[ADDR_W-1:0];
      case (req_command)
         CMD_TRACK: begin
            if ((kind == KIND_ON || kind == KIND_OFF) && in_range) begin
               cls.code = (kind == KIND_ON && req_velocity != 7'd0) ? OP_INC : OP_DEC;
            end else begin
               cls.code = OP_NOP;
            end
         end
         CMD_CLEAR: cls.code = OP_CLEAR;
         CMD_FETCH: cls.code = OP_FETCH;
         default:   cls.code = OP_NOP;
      endcase
   end

   assign req_full = (cnt_ff == 2'd2) || hold;
   assign op_valid = (cnt_ff != 2'd0);
   assign op       = q_ff[rd_ptr_ff];
   assign push     = req_push && !req_full;
   assign pop      = op_valid && op_take;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[rtl/core/mhnt_back.sv]
// Back part of the hanging-note tracker: counter store, scan engine, result queue.
// Depends on mhnt_pkg.
module mhnt_back import mhnt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          op_valid,
   input  op_type        op,
   output logic          op_take,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_item,
   output back_stat_type stat
);

   localparam logic [1:0] S_WIPE  = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_TRACK = 2'd2;
   localparam logic [1:0] S_SCAN  = 2'd3;

   logic [COUNT_WIDTH-1:0] mem [SLOTS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]      rd_addr, wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   mem_we;

   logic [1:0]        state_ff, state_in;
   logic              init_ff, init_in;
   logic [ADDR_W-1:0] wipe_ptr_ff, wipe_ptr_in;
   logic [CURSOR_W-1:0] cur_ff, cur_in;
   logic [CHAN_W-1:0] cur_chan_ff, cur_chan_in;
   logic [KEY_W-1:0]  cur_key_ff, cur_key_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CHAN_W-1:0] scan_chan_ff, scan_chan_in;
   logic [KEY_W-1:0]  scan_key_ff, scan_key_in;
   logic [ADDR_W-1:0] track_addr_ff, track_addr_in;
   logic              track_inc_ff, track_inc_in;

   logic [CURSOR_W:0] next_lin;
   logic [CHAN_W-1:0] adv_chan;
   logic [KEY_W-1:0]  adv_key;
   logic [COUNT_WIDTH-1:0] upd;

   rsp_type     res_ff [2];
   logic        rwr_ff, rrd_ff;
   logic [1:0]  rcnt_ff;
   logic        res_push, res_pop, room;
   rsp_type     res_item;

   assign room      = (rcnt_ff != 2'd2);
   assign rsp_empty = (rcnt_ff == 2'd0);
   assign rsp_item  = res_ff[rrd_ff];
   assign res_pop   = rsp_pop && !rsp_empty;
   assign op_take   = (state_ff == S_IDLE) && op_valid && room;
   assign stat.init_busy = init_ff;

   // step the scan position by one slot and form the saturating counter update
   always_comb begin
      next_lin = (CURSOR_W + 1)'(scan_addr_ff) + (CURSOR_W + 1)'(1);
      if (({1'b0, scan_key_ff} + (KEY_W + 1)'(1)) == (KEY_W + 1)'(PITCHES)) begin
         adv_key  = '0;
         adv_chan = scan_chan_ff + CHAN_W'(1);
      end else begin
         adv_key  = scan_key_ff + KEY_W'(1);
         adv_chan = scan_chan_ff;
      end
      if (track_inc_ff) begin
         upd = (rd_data_ff == COUNT_MAX) ? rd_data_ff : rd_data_ff + COUNT_WIDTH'(1);
      end else begin
         upd = (rd_data_ff == '0) ? rd_data_ff : rd_data_ff - COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      wipe_ptr_in   = wipe_ptr_ff;
      cur_in        = cur_ff;
      cur_chan_in   = cur_chan_ff;
      cur_key_in    = cur_key_ff;
      scan_addr_in  = scan_addr_ff;
      scan_chan_in  = scan_chan_ff;
      scan_key_in   = scan_key_ff;
      track_addr_in = track_addr_ff;
      track_inc_in  = track_inc_ff;
      rd_addr       = scan_addr_ff;
      wr_addr       = wipe_ptr_ff;
      wr_data       = '0;
      mem_we        = 1'b0;
      res_push      = 1'b0;
      res_item      = '0;
      case (state_ff)
         S_WIPE: begin
            mem_we = 1'b1;
            if (wipe_ptr_ff == WIPE_LAST) begin
               state_in = S_IDLE;
               init_in  = 1'b0;
            end else begin
               wipe_ptr_in = wipe_ptr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (op_take) begin
               case (op.code)
                  OP_INC, OP_DEC: begin
                     rd_addr       = op.addr;
                     track_addr_in = op.addr;
                     track_inc_in  = (op.code == OP_INC);
                     state_in      = S_TRACK;
                  end
                  OP_CLEAR: begin
                     wipe_ptr_in = '0;
                     cur_in      = '0;
                     cur_chan_in = '0;
                     cur_key_in  = '0;
                     res_push    = 1'b1;
                     state_in    = S_WIPE;
                  end
                  OP_FETCH: begin
                     if ({1'b0, cur_ff} >= SLOTS_C) begin
                        res_push           = 1'b1;
                        res_item.scan_done = 1'b1;
                        cur_in             = '0;
                        cur_chan_in        = '0;
                        cur_key_in         = '0;
                     end else begin
                        rd_addr      = cur_ff[ADDR_W-1:0];
                        scan_addr_in = cur_ff[ADDR_W-1:0];
                        scan_chan_in = cur_chan_ff;
                        scan_key_in  = cur_key_ff;
                        state_in     = S_SCAN;
                     end
                  end
                  default: res_push = 1'b1;
               endcase
            end
         end
         S_TRACK: begin
            mem_we              = 1'b1;
            wr_addr             = track_addr_ff;
            wr_data             = upd;
            res_push            = 1'b1;
            res_item.note_count = count_to_byte(upd);
            state_in            = S_IDLE;
         end
         S_SCAN: begin
            if (rd_data_ff != '0) begin
               res_push                 = 1'b1;
               res_item.note_off_valid  = 1'b1;
               res_item.note_off_status = KIND_OFF | 8'(scan_chan_ff);
               res_item.note_off_key    = 7'(scan_key_ff);
               res_item.note_count      = count_to_byte(rd_data_ff);
               cur_in                   = next_lin[CURSOR_W-1:0];
               if (next_lin[CURSOR_W-1:0] == '0) begin
                  cur_chan_in = '0;
                  cur_key_in  = '0;
               end else begin
                  cur_chan_in = adv_chan;
                  cur_key_in  = adv_key;
               end
               state_in = S_IDLE;
            end else if (next_lin >= SLOTS_C) begin
               res_push           = 1'b1;
               res_item.scan_done = 1'b1;
               cur_in             = '0;
               cur_chan_in        = '0;
               cur_key_in         = '0;
               state_in           = S_IDLE;
            end else begin
               rd_addr      = next_lin[ADDR_W-1:0];
               scan_addr_in = next_lin[ADDR_W-1:0];
               scan_chan_in = adv_chan;
               scan_key_in  = adv_key;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_WIPE;
         init_ff     <= 1'b1;
         wipe_ptr_ff <= '0;
         cur_ff      <= '0;
         cur_chan_ff <= '0;
         cur_key_ff  <= '0;
         rwr_ff      <= 1'b0;
         rrd_ff      <= 1'b0;
         rcnt_ff     <= 2'd0;
      end else begin
         state_ff    <= state_in;
         init_ff     <= init_in;
         wipe_ptr_ff <= wipe_ptr_in;
         cur_ff      <= cur_in;
         cur_chan_ff <= cur_chan_in;
         cur_key_ff  <= cur_key_in;
         rwr_ff      <= res_push ? !rwr_ff : rwr_ff;
         rrd_ff      <= res_pop ? !rrd_ff : rrd_ff;
         rcnt_ff     <= rcnt_ff + 2'(res_push) - 2'(res_pop);
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      scan_chan_ff  <= scan_chan_in;
      scan_key_ff   <= scan_key_in;
      track_addr_ff <= track_addr_in;
      track_inc_ff  <= track_inc_in;
      if (res_push) begin
         res_ff[rwr_ff] <= res_item;
      end
   end

   // counter store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule
